### rtl/gregorian_date_decrement_macros.svh
// assertion macros for the gregorian date decrement block
// used by the top level only, no other dependencies
`ifndef GREGORIAN_DATE_DECREMENT_MACROS_SVH
`define GREGORIAN_DATE_DECREMENT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define GDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gdd_pkg.sv
// shared types, constants and month table for the date decrement block
// no dependencies
package gdd_pkg;

   localparam int DAY_W   = 5;
   localparam int MON_W   = 4;
   localparam int YEAR_W  = 16;
   localparam int CNT_W   = 15;
   localparam int CMD_W   = 3;
   localparam int RES_W   = 5;
   localparam int ALU_W   = 18;

   localparam logic [CMD_W-1:0] CMD_DAYS       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WEEKS      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MONTHS     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_YEARS      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DECADES    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CENTURY    = 3'd5;
   localparam logic [CMD_W-1:0] CMD_MILLENNIUM = 3'd6;

   localparam logic [MON_W-1:0] MON_JAN = 4'd1;
   localparam logic [MON_W-1:0] MON_FEB = 4'd2;
   localparam logic [MON_W-1:0] MON_DEC = 4'd12;

   // residue of 32767 modulo 25, used when the year wraps downward
   localparam logic [RES_W-1:0] RES_AT_WRAP = 5'd17;
   localparam logic [RES_W-1:0] RES_MAX     = 5'd24;

   typedef struct packed {
      logic [MON_W-1:0]         mon;
      logic signed [YEAR_W-1:0] year;
      logic [RES_W-1:0]         res;
      logic [DAY_W-1:0]         len;
   } cal_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd2:                   d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:                d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

### rtl/gdd_alu.sv
// shared subtract and compare unit of the date decrement block
// depends on gdd_pkg
module gdd_alu (
   input  logic [gdd_pkg::ALU_W-1:0] a,
   input  logic [gdd_pkg::ALU_W-1:0] b,
   output logic [gdd_pkg::ALU_W-1:0] diff,
   output logic                      borrow
);
   import gdd_pkg::*;

   // borrow set means a < b
   assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

### rtl/gdd_cal.sv
// one month step back: previous month, year, year residue mod 25 and month length
// depends on gdd_pkg
module gdd_cal (
   input  logic [gdd_pkg::MON_W-1:0]         mon,
   input  logic signed [gdd_pkg::YEAR_W-1:0] year,
   input  logic [gdd_pkg::RES_W-1:0]         res,
   output gdd_pkg::cal_type                  prev
);
   import gdd_pkg::*;

   logic leap;

   always_comb begin
      prev.mon  = mon;
      prev.year = year;
      prev.res  = res;
      if (mon <= MON_JAN) begin
         prev.mon  = MON_DEC;
         prev.year = year - 16'sd1;
         // most negative year wraps to the most positive one
         if (year == {1'b1, {(YEAR_W-1){1'b0}}}) begin
            prev.res = RES_AT_WRAP;
         end else if (res == '0) begin
            prev.res = RES_MAX;
         end else begin
            prev.res = res - 5'd1;
         end
      end else begin
         prev.mon = mon - 4'd1;
      end
      // divisible by 400 means divisible by 16 and by 25
      leap = (prev.year[1:0] == 2'b00) && ((prev.res != '0) || (prev.year[3:0] == 4'b0000));
      prev.len = month_days(prev.mon, leap);
   end

endmodule

### rtl/gregorian_date_decrement.sv
// top level of the gregorian date decrement block: sequencer and output register
// depends on gdd_pkg, gdd_alu, gdd_cal and gregorian_date_decrement_macros.svh
//
//   channel | direction | beat contents
//   req     | in        | tuser: cmd; tdata: count, in_day, in_month, in_year
//   rsp     | out       | tdata: out_day, out_month, out_year
//
// an item is accepted in idle, then passes the year mod 25 reduction, a sign fix and
// the run: day and week modes step back one month per step until the remainder fits in
// the day, month mode steps back one month per count, the year modes take one subtract;
// the result then goes to the output register; every step goes through the one
// shared subtractor. reset is synchronous and clears the sequencer and rsp_tvalid.
// req_tready is high only when idle; a result held by rsp_tready stalls the
// next item's finish but not its acceptance.
`include "gregorian_date_decrement_macros.svh"

module gregorian_date_decrement (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // count[14:0], in_day[19:15], in_month[23:20], in_year[39:24]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // out_day[4:0], out_month[8:5], out_year[24:9], zeros above
);
   import gdd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MOD  = 5'b00010,
      ST_FIX  = 5'b00100,
      ST_RUN  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [DAY_W-1:0]         day_ff, day_in;
   logic [MON_W-1:0]         mon_ff, mon_in;
   logic signed [YEAR_W-1:0] year_ff, year_in;
   logic [ALU_W-1:0]         rem_ff, rem_in;
   logic [YEAR_W-1:0]        red_ff, red_in;
   logic [3:0]               k_ff, k_in;
   logic [RES_W-1:0]         res_ff, res_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]              rsp_tdata_ff, rsp_tdata_in;

   logic [ALU_W-1:0] alu_a, alu_b, alu_diff;
   logic             alu_borrow;
   cal_type          prev;

   logic [CNT_W-1:0]  req_count;
   logic [DAY_W-1:0]  req_day;
   logic [MON_W-1:0]  req_mon;
   logic [YEAR_W-1:0] year_sub;

   assign req_count = req_tdata[14:0];
   assign req_day   = req_tdata[19:15];
   assign req_mon   = req_tdata[23:20];

   gdd_alu u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .diff   (alu_diff),
      .borrow (alu_borrow)
   );

   gdd_cal u_cal (
      .mon  (mon_ff),
      .year (year_ff),
      .res  (res_ff),
      .prev (prev)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // year amount for the year modes; count sits in the low bits of rem
   always_comb begin
      unique case (cmd_ff)
         CMD_DECADES:    year_sub = 16'({rem_ff[CNT_W-1:0], 3'b000})
                                  + 16'({rem_ff[CNT_W-1:0], 1'b0});
         CMD_CENTURY:    year_sub = 16'd100;
         CMD_MILLENNIUM: year_sub = 16'd1000;
         default:        year_sub = {1'b0, rem_ff[CNT_W-1:0]};
      endcase
   end

   // operand select for the shared subtractor
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         ST_MOD: begin
            alu_a = {2'b00, red_ff};
            alu_b = ALU_W'(25) << k_ff;
         end
         ST_FIX: begin
            alu_a = {13'd0, red_ff[RES_W-1:0]};
            alu_b = year_ff[YEAR_W-1] ? ALU_W'(11) : '0;
         end
         ST_RUN: begin
            unique case (cmd_ff)
               CMD_DAYS, CMD_WEEKS: begin
                  alu_a = rem_ff;
                  alu_b = {13'd0, day_ff};
               end
               CMD_MONTHS: begin
                  alu_a = {13'd0, prev.len};
                  alu_b = {13'd0, day_ff};
               end
               default: begin
                  alu_a = {2'b00, year_ff};
                  alu_b = {2'b00, year_sub};
               end
            endcase
         end
         default: begin
            alu_a = '0;
            alu_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      day_in        = day_ff;
      mon_in        = mon_ff;
      year_in       = year_ff;
      rem_in        = rem_ff;
      red_in        = red_ff;
      k_in          = k_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in  = req_tuser;
               day_in  = (req_day == '0) ? 5'd1 : req_day;
               mon_in  = ((req_mon < MON_JAN) || (req_mon > MON_DEC)) ? MON_DEC : req_mon;
               year_in = req_tdata[39:24];
               red_in  = req_tdata[39:24];
               k_in    = 4'd11;
               if (req_tuser == CMD_WEEKS) begin
                  rem_in = {req_count, 3'b000} - {3'b000, req_count};
               end else begin
                  rem_in = {3'b000, req_count};
               end
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            // restoring reduction of the unsigned year modulo 25
            if (!alu_borrow) begin
               red_in = alu_diff[YEAR_W-1:0];
            end
            k_in = k_ff - 4'd1;
            if (k_ff == '0) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // a negative year is 65536 below its unsigned form, 65536 mod 25 is 11
            res_in   = alu_borrow ? 5'(alu_diff[RES_W-1:0] + 5'd25) : alu_diff[RES_W-1:0];
            state_in = ST_RUN;
         end
         ST_RUN: begin
            unique case (cmd_ff)
               CMD_DAYS, CMD_WEEKS: begin
                  if (rem_ff == '0) begin
                     state_in = ST_DONE;
                  end else if (alu_borrow) begin
                     day_in = 5'(5'd0 - alu_diff[DAY_W-1:0]);
                     rem_in = '0;
                  end else begin
                     rem_in  = alu_diff;
                     mon_in  = prev.mon;
                     year_in = prev.year;
                     res_in  = prev.res;
                     day_in  = prev.len;
                  end
               end
               CMD_MONTHS: begin
                  if (rem_ff == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     rem_in  = rem_ff - ALU_W'(1);
                     mon_in  = prev.mon;
                     year_in = prev.year;
                     res_in  = prev.res;
                     if (alu_borrow) begin
                        day_in = prev.len;
                     end
                  end
               end
               CMD_YEARS, CMD_DECADES, CMD_CENTURY, CMD_MILLENNIUM: begin
                  year_in  = alu_diff[YEAR_W-1:0];
                  state_in = ST_DONE;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'd0, year_ff, mon_ff, day_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      day_ff       <= day_in;
      mon_ff       <= mon_in;
      year_ff      <= year_in;
      rem_ff       <= rem_in;
      red_ff       <= red_in;
      k_ff         <= k_in;
      res_ff       <= res_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   `GDD_ASSERT_NEXT(a_accept_starts_reduction, clock, reset, req_tvalid && req_tready, state_ff == ST_MOD, "accepted beat did not start the year reduction")
   `GDD_ASSERT_NOW(a_residue_in_range, clock, reset, state_ff == ST_RUN, res_ff <= RES_MAX, "year residue out of range")
   `GDD_ASSERT_NOW(a_run_date_sane, clock, reset, state_ff == ST_RUN, (day_ff != '0) && (mon_ff >= MON_JAN) && (mon_ff <= MON_DEC), "working date out of range")
   `GDD_ASSERT_NOW(a_rsp_month_sane, clock, reset, rsp_tvalid, (rsp_tdata[8:5] >= MON_JAN) && (rsp_tdata[8:5] <= MON_DEC) && (rsp_tdata[4:0] != '0), "result date out of range")

endmodule

### sim/gregorian_date_decrement_test.sv
// self-checking testbench for gregorian_date_decrement: directed and random dates
// through the req stream, results on rsp compared with a built-in date predictor
// depends on gdd_pkg and the gregorian_date_decrement rtl
module gregorian_date_decrement_test;
   import gdd_pkg::*;

   // no name in the package for the unused command code
   localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;
   localparam int STALL_LIMIT = 150000;
   localparam int HOLD_CYCLES = 600;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CNT_W-1:0]  count;
      logic [DAY_W-1:0]  day;
      logic [MON_W-1:0]  month;
      logic [YEAR_W-1:0] year;
   } date_req_type;

   typedef struct packed {
      logic [DAY_W-1:0]  day;
      logic [MON_W-1:0]  month;
      logic [YEAR_W-1:0] year;
   } date_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata;    // count[14:0], in_day[19:15], in_month[23:20], in_year[39:24]
   logic [2:0]  req_tuser;    // cmd[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;    // out_day[4:0], out_month[8:5], out_year[24:9]

   date_req_type req_beat = '0;
   date_req_type date_reqs[$];
   date_type     earlier_dates[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int results_seen = 0;
   int hold_left = 0;
   bit pressure_done = 1'b0;
   int quiet_cycles = 0;

   assign req_tdata = {req_beat.year, req_beat.month, req_beat.day, req_beat.count};
   assign req_tuser = req_beat.cmd;

   gregorian_date_decrement u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int wrap_year(input int y);
      logic signed [15:0] t;
      t = y[15:0];
      return t;
   endfunction

   function automatic bit is_leap(input int y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   function automatic int month_length(input int y, input int m);
      case (m)
         2:             return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic date_type prior_date(input date_req_type r);
      int d;
      int m;
      int y;
      int left;
      int i;
      int len;
      date_type o;
      d = (r.day == 0) ? 1 : int'(r.day);
      m = (r.month < 1 || r.month > 12) ? 12 : int'(r.month);
      y = wrap_year(int'(r.year));
      case (r.cmd)
         CMD_DAYS, CMD_WEEKS: begin
            left = (r.cmd == CMD_WEEKS) ? int'(r.count) * 7 : int'(r.count);
            while (left > 0) begin
               if (left < d) begin
                  d = d - left;
                  left = 0;
               end else begin
                  left = left - d;
                  if (m <= 1) begin
                     m = 12;
                     y = wrap_year(y - 1);
                  end else begin
                     m = m - 1;
                  end
                  d = month_length(y, m);
               end
            end
         end
         CMD_MONTHS: begin
            for (i = 0; i < int'(r.count); i++) begin
               if (m <= 1) begin
                  m = 12;
                  y = wrap_year(y - 1);
               end else begin
                  m = m - 1;
               end
               len = month_length(y, m);
               if (d > len) d = len;
            end
         end
         CMD_YEARS:      y = wrap_year(y - int'(r.count));
         CMD_DECADES:    y = wrap_year(y - ((int'(r.count) * 10) & 16'hFFFF));
         CMD_CENTURY:    y = wrap_year(y - 100);
         CMD_MILLENNIUM: y = wrap_year(y - 1000);
         default: ;
      endcase
      o.day = d[4:0];
      o.month = m[3:0];
      o.year = y[15:0];
      return o;
   endfunction

   function automatic date_req_type date_req(input logic [2:0] cmd, input int count,
                                             input int day, input int month, input int year);
      date_req_type r;
      r.cmd = cmd;
      r.count = count[14:0];
      r.day = day[4:0];
      r.month = month[3:0];
      r.year = year[15:0];
      return r;
   endfunction

   function automatic date_req_type random_date_req();
      date_req_type r;
      int y;
      r.cmd = CMD_W'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0:       r.count = CNT_W'($urandom_range(0, 32767));
         1, 2, 3: r.count = CNT_W'($urandom_range(0, 15));
         default: r.count = CNT_W'($urandom_range(0, 800));
      endcase
      case ($urandom_range(0, 3))
         0:       y = $urandom_range(0, 65535);
         1:       y = ($urandom_range(0, 1) != 0) ? -32768 + $urandom_range(0, 40)
                                                  : 32767 - $urandom_range(0, 40);
         2:       y = (int'($urandom_range(0, 600)) - 300) * 100 + int'($urandom_range(0, 8)) - 4;
         default: y = 1800 + $urandom_range(0, 300);
      endcase
      r.year = y[15:0];
      if ($urandom_range(0, 99) < 80) begin
         // well-formed date
         r.month = MON_W'($urandom_range(1, 12));
         r.day = DAY_W'($urandom_range(1, month_length(wrap_year(y), int'(r.month))));
      end else begin
         r.month = MON_W'($urandom_range(0, 15));
         r.day = DAY_W'($urandom_range(0, 31));
      end
      return r;
   endfunction

   task automatic check_result(input logic [31:0] beat);
      date_type want;
      date_type got;
      got.day = beat[4:0];
      got.month = beat[8:5];
      got.year = beat[24:9];
      if (earlier_dates.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat: day %0d month %0d year %0d",
                     got.day, got.month, $signed(got.year));
      end else begin
         want = earlier_dates.pop_front();
         if (got.day !== want.day || got.month !== want.month || got.year !== want.year) begin
            mismatches++;
            if (mismatches <= 10)
               $display("date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        want.day, want.month, $signed(want.year),
                        got.day, got.month, $signed(got.year));
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            earlier_dates.push_back(prior_date(req_beat));
         if (!req_tvalid || req_tready) begin
            if (date_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_beat <= date_reqs.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor; also holds the receiver off once for a long stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            check_result(rsp_tdata);
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!pressure_done && results_seen >= 30) begin
            pressure_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drain();
      while (date_reqs.size() != 0 || req_tvalid || earlier_dates.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_batch(input int send_pct, input int recv_pct, input int n);
      int i;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (i = 0; i < n; i++)
         date_reqs.push_back(random_date_req());
      drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero count, leap rules, year wrap, largest counts
      date_reqs.push_back(date_req(CMD_DAYS, 0, 15, 6, 2023));
      date_reqs.push_back(date_req(CMD_DAYS, 1, 1, 3, 2000));
      date_reqs.push_back(date_req(CMD_DAYS, 1, 1, 3, 1900));
      date_reqs.push_back(date_req(CMD_DAYS, 1, 1, 3, -4));
      date_reqs.push_back(date_req(CMD_DAYS, 1, 1, 1, -32768));
      date_reqs.push_back(date_req(CMD_DAYS, 32767, 31, 12, 32767));
      date_reqs.push_back(date_req(CMD_WEEKS, 32767, 1, 1, -32768));
      date_reqs.push_back(date_req(CMD_WEEKS, 1, 3, 3, 2024));
      date_reqs.push_back(date_req(CMD_MONTHS, 1, 31, 3, 2023));
      date_reqs.push_back(date_req(CMD_MONTHS, 32767, 31, 1, -32768));
      date_reqs.push_back(date_req(CMD_MONTHS, 13, 31, 5, 2024));
      date_reqs.push_back(date_req(CMD_YEARS, 32767, 1, 1, -32768));
      date_reqs.push_back(date_req(CMD_YEARS, 1, 29, 2, 2024));
      date_reqs.push_back(date_req(CMD_DECADES, 32767, 10, 10, 0));
      date_reqs.push_back(date_req(CMD_DECADES, 5, 4, 7, 1999));
      date_reqs.push_back(date_req(CMD_CENTURY, 32767, 20, 8, -32700));
      date_reqs.push_back(date_req(CMD_MILLENNIUM, 0, 2, 9, -32000));
      // out-of-range day and month get cleaned up
      date_reqs.push_back(date_req(CMD_NONE, 123, 0, 0, 1234));
      date_reqs.push_back(date_req(CMD_DAYS, 5, 0, 13, 2001));
      date_reqs.push_back(date_req(CMD_MONTHS, 2, 31, 15, 2001));
      // day past the end of its month
      date_reqs.push_back(date_req(CMD_DAYS, 3, 31, 2, 2023));
      date_reqs.push_back(date_req(CMD_MONTHS, 1, 31, 4, 2023));
      date_reqs.push_back(date_req(CMD_YEARS, 0, 31, 11, 2000));
      date_reqs.push_back(date_req(CMD_NONE, 32767, 31, 15, 32767));
      drain();

      run_batch(0, 0, 25);
      run_batch(66, 0, 25);
      run_batch(0, 66, 25);
      run_batch(24, 24, 25);

      repeat (40) @(negedge clock);
      if (mismatches == 0 && earlier_dates.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
